>>> src/spgs_pkg.sv
// Shared types, constants and state codes for the sphere potential gradient accumulator.
package spgs_pkg;

    localparam int FRAC_BITS_DEF   = 30;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int IN_W            = 32;
    localparam int SUM_W           = 64;
    localparam int GAP_W           = 31;
    localparam logic [GAP_W-1:0] MIN_GAP_RST = 31'd1048576;

    typedef struct packed {
        logic [SUM_W-1:0]   w;
        logic [2:0][IN_W-1:0] q;
        logic               last;
        logic               clamp;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_GAP,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_HI,
        B_LO,
        B_MAG,
        B_ADD,
        B_OUT
    } t_back_state;

endpackage

>>> src/spgs_front.sv
// Front end: takes a word, forms the dot product, clamps the gap and divides for the weight.
module spgs_front
    import spgs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic signed [IN_W-1:0]  i_pos_x,
    input  logic signed [IN_W-1:0]  i_pos_y,
    input  logic signed [IN_W-1:0]  i_pos_z,
    input  logic signed [IN_W-1:0]  i_planet_x,
    input  logic signed [IN_W-1:0]  i_planet_y,
    input  logic signed [IN_W-1:0]  i_planet_z,
    input  logic                    i_is_last,
    input  logic [GAP_W-1:0]        i_min_gap,
    output t_job                    o_job,
    output logic                    o_job_valid,
    input  logic                    i_job_ready
);

    localparam int QBITS = 2 * FRAC_BITS;
    localparam int CW    = $clog2(QBITS + 1);

    t_front_state r_state, n_state;

    logic signed [IN_W-1:0]  r_p [3];
    logic signed [IN_W-1:0]  r_q [3];
    logic                    r_last;
    logic [1:0]              r_mi;
    logic signed [SUM_W-1:0] r_dot;
    logic [SUM_W-1:0]        r_gap;
    logic                    r_clamp;
    logic [SUM_W-1:0]        r_rem;
    logic [SUM_W-1:0]        r_quo;
    logic [CW-1:0]           r_cnt;

    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] gap_raw;
    logic signed [SUM_W-1:0] gmin;
    logic [SUM_W-1:0]        rem_sh;
    logic                    ge;
    logic                    accept;

    assign accept  = i_push && !o_full;
    assign prod    = SUM_W'(r_p[r_mi]) * SUM_W'(r_q[r_mi]);
    assign gap_raw = (SUM_W'(64'sd1) <<< FRAC_BITS) - r_dot;
    assign gmin    = (i_min_gap == '0) ? SUM_W'(64'sd1)
                                       : $signed({{(SUM_W-GAP_W){1'b0}}, i_min_gap});
    // dividend is a single one bit at position QBITS
    assign rem_sh  = {r_rem[SUM_W-2:0], (r_cnt == CW'(QBITS))};
    assign ge      = rem_sh >= r_gap;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_MUL;
            F_MUL:  if (r_mi == 2'd2) n_state = F_GAP;
            F_GAP:  n_state = F_DIV;
            F_DIV:  if (r_cnt == '0) n_state = F_PUSH;
            F_PUSH: if (i_job_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_full      = (r_state != F_IDLE);
        o_job_valid = (r_state == F_PUSH);
        o_job.w     = r_quo;
        o_job.q[0]  = r_q[0];
        o_job.q[1]  = r_q[1];
        o_job.q[2]  = r_q[2];
        o_job.last  = r_last;
        o_job.clamp = r_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    r_p[0] <= i_pos_x;
                    r_p[1] <= i_pos_y;
                    r_p[2] <= i_pos_z;
                    r_q[0] <= i_planet_x;
                    r_q[1] <= i_planet_y;
                    r_q[2] <= i_planet_z;
                    r_last <= i_is_last;
                    r_mi   <= 2'd0;
                    r_dot  <= '0;
                end
            end
            F_MUL: begin
                r_dot <= r_dot + (prod >>> FRAC_BITS);
                r_mi  <= r_mi + 2'd1;
            end
            F_GAP: begin
                r_clamp <= gap_raw < gmin;
                r_gap   <= (gap_raw < gmin) ? gmin : gap_raw;
                r_rem   <= '0;
                r_quo   <= '0;
                r_cnt   <= CW'(QBITS);
            end
            F_DIV: begin
                r_rem <= ge ? (rem_sh - r_gap) : rem_sh;
                r_quo <= {r_quo[SUM_W-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
            end
            default: begin
            end
        endcase
    end

    a_rem_below_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_DIV) |-> (r_rem < r_gap))
        else $error("divider remainder not below divisor");

endmodule

>>> src/spgs_queue.sv
// Short register queue of jobs between front and back.
module spgs_queue
    import spgs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_data,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop_data,
    input  logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_push_ready = (r_cnt != NW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + NW'(do_push) - NW'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> src/spgs_back.sv
// Back end: scales each planet component by the weight and adds the negated product into the saturating sums.
module spgs_back
    import spgs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_job                    i_job,
    input  logic                    i_job_valid,
    output logic                    o_job_pop,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [SUM_W-1:0] o_grad_x,
    output logic signed [SUM_W-1:0] o_grad_y,
    output logic signed [SUM_W-1:0] o_grad_z,
    output logic                    o_near_flag,
    output logic                    o_sat_flag
);

    localparam int SH = 32 - FRAC_BITS;
    localparam logic [SUM_W-1:0] MAXV   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] HI_LIM = MAXV >> SH;

    t_back_state r_state, n_state;

    t_job                    r_job;
    logic [1:0]              r_comp;
    logic signed [SUM_W-1:0] r_sum [3];
    logic                    r_near;
    logic                    r_ovf;
    logic [SUM_W-1:0]        r_hi;
    logic [SUM_W-1:0]        r_lo;
    logic signed [SUM_W-1:0] r_contrib;
    logic                    r_out_valid;

    logic [IN_W-1:0]         qc;
    logic [IN_W-1:0]         m;
    logic [SUM_W-1:0]        hi_sh;
    logic [SUM_W-1:0]        mag;
    logic                    mag_sat;
    logic signed [SUM_W:0]   sum_ext;
    logic signed [SUM_W-1:0] sum_new;
    logic                    add_sat;

    assign qc    = r_job.q[r_comp];
    assign m     = qc[IN_W-1] ? (~qc + IN_W'(1)) : qc;
    assign hi_sh = r_hi << SH;

    always_comb begin
        mag_sat = 1'b0;
        mag     = hi_sh + r_lo;
        if (r_hi > HI_LIM) begin
            mag_sat = 1'b1;
            mag     = MAXV;
        end else if (hi_sh > (MAXV - r_lo)) begin
            mag_sat = 1'b1;
            mag     = MAXV;
        end
    end

    always_comb begin
        sum_ext = {r_sum[r_comp][SUM_W-1], r_sum[r_comp]}
                + {r_contrib[SUM_W-1], r_contrib};
        add_sat = sum_ext[SUM_W] != sum_ext[SUM_W-1];
        if (add_sat) begin
            sum_new = sum_ext[SUM_W] ? $signed(~MAXV) : $signed(MAXV);
        end else begin
            sum_new = sum_ext[SUM_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_job_valid) n_state = B_HI;
            B_HI:   n_state = B_LO;
            B_LO:   n_state = B_MAG;
            B_MAG:  n_state = B_ADD;
            B_ADD: begin
                if (r_comp != 2'd2) n_state = B_HI;
                else if (r_job.last) n_state = B_OUT;
                else n_state = B_IDLE;
            end
            B_OUT:  if (!r_out_valid) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = (r_state == B_IDLE) && i_job_valid;
        empty     = !r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_comp      <= 2'd0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
            r_near      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job  <= i_job;
                        r_comp <= 2'd0;
                        r_near <= r_near | i_job.clamp;
                    end
                end
                B_HI: r_hi <= SUM_W'(r_job.w[SUM_W-1:32]) * SUM_W'(m);
                B_LO: r_lo <= (SUM_W'(r_job.w[31:0]) * SUM_W'(m)) >> FRAC_BITS;
                B_MAG: begin
                    r_contrib <= qc[IN_W-1] ? $signed(mag) : -$signed(mag);
                    r_ovf     <= r_ovf | mag_sat;
                end
                B_ADD: begin
                    r_sum[r_comp] <= sum_new;
                    r_ovf         <= r_ovf | add_sat;
                    if (r_comp != 2'd2) begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
                B_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_sum[0]    <= '0;
                        r_sum[1]    <= '0;
                        r_sum[2]    <= '0;
                        r_near      <= 1'b0;
                        r_ovf       <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == B_OUT && !r_out_valid) begin
            o_grad_x    <= r_sum[0];
            o_grad_y    <= r_sum[1];
            o_grad_z    <= r_sum[2];
            o_near_flag <= r_near;
            o_sat_flag  <= r_ovf;
        end
    end

    a_comp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_comp != 2'd3)
        else $error("component index out of range");

endmodule

>>> src/sphere_potential_gradient_sum.sv
// Top level of the sphere potential gradient accumulator.
//
//  channel   direction  handshake            payload
//  input     in         push / full          i_pos_*, i_planet_*, i_is_last
//  result    out        empty / pop          o_grad_*, o_near_flag, o_sat_flag
//  config    in         i_cfg_we (no wait)   i_cfg_data (min gap)
//
// Front end takes one word at a time: an accept step, three multiply steps,
// one clamp step, a bit-per-cycle divider for the weight (2*FRAC_BITS+1
// steps), and a hand-off step that waits until the queue has room. Back end
// runs HI, LO, MAG and ADD per component, and B_OUT after the last word.
// Reset is synchronous, clears sums, flags and queue and sets min gap to MIN_GAP_RST.
// A result waiting on the output holds the back end; the job queue lets the
// front keep taking words meanwhile until it fills.
module sphere_potential_gradient_sum
    import spgs_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [IN_W-1:0]  i_pos_x,
    input  logic signed [IN_W-1:0]  i_pos_y,
    input  logic signed [IN_W-1:0]  i_pos_z,
    input  logic signed [IN_W-1:0]  i_planet_x,
    input  logic signed [IN_W-1:0]  i_planet_y,
    input  logic signed [IN_W-1:0]  i_planet_z,
    input  logic                    i_is_last,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [SUM_W-1:0] o_grad_x,
    output logic signed [SUM_W-1:0] o_grad_y,
    output logic signed [SUM_W-1:0] o_grad_z,
    output logic                    o_near_flag,
    output logic                    o_sat_flag,
    input  logic                    i_cfg_we,
    input  logic [GAP_W-1:0]        i_cfg_data
);

    logic [GAP_W-1:0] r_min_gap;

    t_job f_job;
    logic f_valid;
    logic f_ready;
    t_job b_job;
    logic b_valid;
    logic b_pop;

    // min gap register, written whenever the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= MIN_GAP_RST;
        end else if (i_cfg_we) begin
            r_min_gap <= i_cfg_data;
        end
    end

    spgs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_planet_x  (i_planet_x),
        .i_planet_y  (i_planet_y),
        .i_planet_z  (i_planet_z),
        .i_is_last   (i_is_last),
        .i_min_gap   (r_min_gap),
        .o_job       (f_job),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready)
    );

    spgs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_data  (f_job),
        .o_push_ready (f_ready),
        .o_pop_valid  (b_valid),
        .o_pop_data   (b_job),
        .i_pop        (b_pop)
    );

    spgs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (b_job),
        .i_job_valid (b_valid),
        .o_job_pop   (b_pop),
        .empty       (empty),
        .pop         (pop),
        .o_grad_x    (o_grad_x),
        .o_grad_y    (o_grad_y),
        .o_grad_z    (o_grad_z),
        .o_near_flag (o_near_flag),
        .o_sat_flag  (o_sat_flag)
    );

endmodule
